@@ hw/rtl/stok_pkg.sv @@
// Shared types, token kind codes and character classes for the source tokenizer.
package stok_pkg;

  typedef logic [4:0] kind_t;

  // Token kinds
  localparam kind_t KIND_SYM    = 5'd0;
  localparam kind_t KIND_INT    = 5'd1;
  localparam kind_t KIND_REAL   = 5'd2;
  localparam kind_t KIND_PROC   = 5'd3;
  localparam kind_t KIND_RECORD = 5'd4;
  localparam kind_t KIND_VAR    = 5'd5;
  localparam kind_t KIND_RETURN = 5'd6;
  localparam kind_t KIND_END    = 5'd7;
  localparam kind_t KIND_COMMA  = 5'd8;
  localparam kind_t KIND_PLUS   = 5'd9;
  localparam kind_t KIND_MINUS  = 5'd10;
  localparam kind_t KIND_STAR   = 5'd11;
  localparam kind_t KIND_SLASH  = 5'd12;
  localparam kind_t KIND_EQUAL  = 5'd13;
  localparam kind_t KIND_DOT    = 5'd14;
  localparam kind_t KIND_LT     = 5'd15;
  localparam kind_t KIND_GT     = 5'd16;
  localparam kind_t KIND_COLON  = 5'd17;
  localparam kind_t KIND_LBRACE = 5'd18;
  localparam kind_t KIND_RBRACE = 5'd19;
  localparam kind_t KIND_LBRACK = 5'd20;
  localparam kind_t KIND_RBRACK = 5'd21;
  localparam kind_t KIND_LPAREN = 5'd22;
  localparam kind_t KIND_RPAREN = 5'd23;
  localparam kind_t KIND_EOF    = 5'd24;
  localparam kind_t KIND_ERR    = 5'd25;

  // Keyword spellings, packed one character per byte, last character lowest
  localparam logic [47:0] KW_PROC   = 48'h0000_7072_6F63;
  localparam logic [47:0] KW_RECORD = 48'h7265_636F_7264;
  localparam logic [47:0] KW_VAR    = 48'h0000_0076_6172;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;
  localparam logic [47:0] KW_END    = 48'h0000_0065_6E64;
  localparam logic [47:0] KW_FULL   = 48'hFFFF_FFFF_FFFF;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_US   = 8'h5F;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  // Fraction digits kept in a real
  localparam int unsigned MAX_FRAC_DIGITS = 18;

  // Result queue
  localparam int unsigned RESULT_DEPTH = 4;

  typedef struct packed {
    kind_t              kind;
    logic [19:0]        line;
    logic [15:0]        column;
    logic [31:0]        sym_offset;
    logic [31:0]        sym_length;
    logic signed [63:0] int_value;
    logic [59:0]        frac_value;
    logic [4:0]         frac_digits;
    logic               last;
  } result_t;

  // Results written by the scanner for one byte
  typedef struct packed {
    logic [1:0] wr_count;
    result_t    res0;
    result_t    res1;
  } emit_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      ",":     k = KIND_COMMA;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "=":     k = KIND_EQUAL;
      ".":     k = KIND_DOT;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      ":":     k = KIND_COLON;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      default: k = KIND_ERR;
    endcase
    return k;
  endfunction

  function automatic kind_t keyword_kind(input logic [47:0] kw);
    kind_t k;
    case (kw)
      KW_PROC:   k = KIND_PROC;
      KW_RECORD: k = KIND_RECORD;
      KW_VAR:    k = KIND_VAR;
      KW_RETURN: k = KIND_RETURN;
      KW_END:    k = KIND_END;
      default:   k = KIND_SYM;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/stok_if.sv @@
// Valid/ready channel interfaces for source bytes and tokens.
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_in;

  modport source (output valid, output mode, output byte_in, input ready);
  modport sink   (input valid, input mode, input byte_in, output ready);
endinterface

interface stok_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         kind;
  logic [19:0]        line;
  logic [15:0]        column;
  logic [31:0]        sym_offset;
  logic [31:0]        sym_length;
  logic signed [63:0] int_value;
  logic [59:0]        frac_value;
  logic [4:0]         frac_digits;
  logic               last;

  modport source (
    output valid, output kind, output line, output column, output sym_offset,
    output sym_length, output int_value, output frac_value, output frac_digits,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input line, input column, input sym_offset,
    input sym_length, input int_value, input frac_value, input frac_digits,
    input last, output ready
  );
endinterface

@@ hw/rtl/stok_scan.sv @@
// Scanner: lexer state, position counters and token results for one byte.
module stok_scan #(
  parameter int POS_BITS  = 32,
  parameter int LINE_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               in_mode,
  input  logic [7:0]         in_byte,
  output stok_pkg::emit_t    emit
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_COMMENT = 5'b00010,
    ST_SYM     = 5'b00100,
    ST_INT     = 5'b01000,
    ST_FRAC    = 5'b10000
  } scan_state_t;

  scan_state_t          state_r, state_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [15:0]          col_r, col_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  start_r, start_nxt;
  logic [47:0]          kw_r, kw_nxt;
  logic [63:0]          int_r, int_nxt;
  logic [59:0]          frac_r, frac_nxt;
  logic [4:0]           fcnt_r, fcnt_nxt;

  logic                 c_space, c_alpha, c_digit, c_us, c_hash, c_lf, c_dot;
  logic                 in_tok, in_comment, cont, flush, idle_path, second, nl;
  logic [63:0]          int_mul;
  logic [59:0]          frac_mul;
  logic [POS_BITS-1:0]  sym_len;
  stok_pkg::result_t    res_flush, res_second;

  // Classify the byte
  always_comb begin
    c_space = stok_pkg::is_space(in_byte);
    c_alpha = stok_pkg::is_alpha(in_byte);
    c_digit = stok_pkg::is_digit(in_byte);
    c_us    = (in_byte == stok_pkg::CH_US);
    c_hash  = (in_byte == stok_pkg::CH_HASH);
    c_lf    = (in_byte == stok_pkg::CH_LF);
    c_dot   = (in_byte == stok_pkg::CH_DOT);
  end

  // Decide whether the byte extends the token in progress
  always_comb begin
    in_tok     = 1'b0;
    in_comment = 1'b0;
    cont       = 1'b0;
    case (state_r)
      ST_COMMENT: in_comment = 1'b1;
      ST_SYM: begin
        in_tok = 1'b1;
        cont   = c_alpha | c_digit | c_us;
      end
      ST_INT: begin
        in_tok = 1'b1;
        cont   = c_digit | c_dot;
      end
      ST_FRAC: begin
        in_tok = 1'b1;
        cont   = c_digit;
      end
      default: ;
    endcase
    flush     = in_tok & (in_mode | ~cont);
    idle_path = ~in_mode & ~in_comment & ~(in_tok & cont);
    second    = in_mode | (idle_path & ~c_space & ~c_hash & ~c_alpha & ~c_us & ~c_digit);
    nl        = ~in_mode & c_lf;
  end

  // Times ten plus digit, as shifts and adds
  assign int_mul  = {int_r[60:0], 3'b000} + {int_r[62:0], 1'b0} + 64'(in_byte[3:0]);
  assign frac_mul = {frac_r[56:0], 3'b000} + {frac_r[58:0], 1'b0} + 60'(in_byte[3:0]);

  // Advance position, column and line
  always_comb begin
    pos_nxt  = pos_r;
    col_nxt  = col_r;
    line_nxt = line_r;
    if (!in_mode) begin
      pos_nxt = pos_r + 1'b1;
      if (nl) begin
        col_nxt = 16'd1;
        if (!(&line_r)) begin
          line_nxt = line_r + 1'b1;
        end
      end else if (!(&col_r)) begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // Next lexer state and accumulators
  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    kw_nxt    = kw_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    if (in_mode) begin
      state_nxt = ST_IDLE;
    end else if (in_comment) begin
      if (c_lf) begin
        state_nxt = ST_IDLE;
      end
    end else if (in_tok && cont) begin
      case (state_r)
        ST_SYM: begin
          if (kw_r[47:40] != 8'd0) begin
            kw_nxt = stok_pkg::KW_FULL;
          end else begin
            kw_nxt = {kw_r[39:0], in_byte};
          end
        end
        ST_INT: begin
          if (c_digit) begin
            int_nxt = int_mul;
          end else begin
            state_nxt = ST_FRAC;
          end
        end
        ST_FRAC: begin
          if (fcnt_r < 5'(stok_pkg::MAX_FRAC_DIGITS)) begin
            frac_nxt = frac_mul;
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      state_nxt = ST_IDLE;
      if (c_hash) begin
        state_nxt = ST_COMMENT;
      end else if (c_alpha || c_us) begin
        state_nxt = ST_SYM;
        start_nxt = pos_r;
        kw_nxt    = {40'd0, in_byte};
      end else if (c_digit) begin
        state_nxt = ST_INT;
        int_nxt   = 64'(in_byte[3:0]);
        frac_nxt  = '0;
        fcnt_nxt  = '0;
      end
    end
  end

  // Build the token that ends here and the one this byte makes
  assign sym_len = pos_r - start_r;

  always_comb begin
    res_flush        = '0;
    res_flush.line   = 20'(32'(line_r));
    res_flush.column = col_r;
    case (state_r)
      ST_SYM: begin
        res_flush.kind       = stok_pkg::keyword_kind(kw_r);
        res_flush.sym_offset = 32'(64'(start_r));
        res_flush.sym_length = 32'(64'(sym_len));
      end
      ST_INT: begin
        res_flush.kind      = stok_pkg::KIND_INT;
        res_flush.int_value = int_r;
      end
      ST_FRAC: begin
        res_flush.kind        = stok_pkg::KIND_REAL;
        res_flush.int_value   = int_r;
        res_flush.frac_value  = frac_r;
        res_flush.frac_digits = fcnt_r;
      end
      default: ;
    endcase

    res_second        = '0;
    res_second.kind   = in_mode ? stok_pkg::KIND_EOF : stok_pkg::punct_kind(in_byte);
    res_second.line   = 20'(32'(line_nxt));
    res_second.column = col_nxt;
    res_second.last   = 1'b1;

    emit = '0;
    if (fire) begin
      if (flush && second) begin
        emit.wr_count = 2'd2;
        emit.res0     = res_flush;
        emit.res1     = res_second;
      end else if (flush) begin
        emit.wr_count  = 2'd1;
        emit.res0      = res_flush;
        emit.res0.last = 1'b1;
      end else if (second) begin
        emit.wr_count = 2'd1;
        emit.res0     = res_second;
      end
    end
  end

  // Hold state unless a byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      line_r  <= LINE_BITS'(1);
      col_r   <= 16'd1;
      pos_r   <= '0;
      start_r <= '0;
      kw_r    <= '0;
      int_r   <= '0;
      frac_r  <= '0;
      fcnt_r  <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      kw_r    <= kw_nxt;
      int_r   <= int_nxt;
      frac_r  <= frac_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  a_eof_idles: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_mode |=> state_r == ST_IDLE)
    else $error("scanner not idle after end of source");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter reached zero");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 5'(stok_pkg::MAX_FRAC_DIGITS))
    else $error("fraction digit count beyond limit");

endmodule

@@ hw/rtl/stok_fifo.sv @@
// Result queue: takes up to two tokens a cycle, hands out one per transfer.
module stok_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  stok_pkg::emit_t    emit,
  input  logic               pop,
  output stok_pkg::result_t  head,
  output logic               head_valid,
  output logic               room
);

  localparam int unsigned DEPTH    = stok_pkg::RESULT_DEPTH;
  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = PTR_BITS + 1;

  stok_pkg::result_t   mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [PTR_BITS-1:0] wr_ptr_one;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  // Room for the most a single byte can produce
  assign room       = (count_r <= CNT_BITS'(DEPTH - 2));
  assign wr_ptr_one = PTR_BITS'(wr_ptr_r + 1'b1);

  always_comb begin
    wr_ptr_nxt = PTR_BITS'(wr_ptr_r + emit.wr_count);
    rd_ptr_nxt = PTR_BITS'(rd_ptr_r + pop);
    count_nxt  = CNT_BITS'(count_r + emit.wr_count - pop);
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (emit.wr_count != 2'd0) begin
      mem_r[wr_ptr_r] <= emit.res0;
    end
    if (emit.wr_count == 2'd2) begin
      mem_r[wr_ptr_one] <= emit.res1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) + 32'(emit.wr_count) <= DEPTH)
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("result queue read while empty");

endmodule

@@ hw/rtl/source_tokenizer.sv @@
// Top level of the streaming source tokenizer.
// Takes one source byte (or an end-of-source item) per transfer and returns tokens,
// one per transfer. The scanner updates its state from a registered input byte, so
// a new byte is taken every cycle while two queue entries are free; a byte that
// both ends a symbol or number and forms a punctuator (or an end-of-source item
// that flushes a token) yields two tokens, which leave one after the other. Tokens
// wait in a four-entry result queue, and the scanner moves on only while two
// entries are free, so the input stalls only when the output is stalled or a run
// of two-token bytes fills the queue. A token passes through the input register
// and the result queue before the output. No clearing pass is needed after reset.
module source_tokenizer #(
  parameter int POS_BITS  = 32,
  parameter int LINE_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  stok_in_if.sink    in_ch,
  stok_out_if.source out_ch
);

  logic              in_vld_r;
  logic              in_mode_r;
  logic [7:0]        in_byte_r;
  logic              fire;
  logic              room;
  logic              head_valid;
  stok_pkg::emit_t   emit;
  stok_pkg::result_t head;

  assign fire        = in_vld_r & room;
  assign in_ch.ready = ~in_vld_r | fire;

  // Register the incoming item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_mode_r <= in_ch.mode;
      in_byte_r <= in_ch.byte_in;
    end
  end

  stok_scan #(
    .POS_BITS  (POS_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_mode (in_mode_r),
    .in_byte (in_byte_r),
    .emit    (emit)
  );

  stok_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .pop        (out_ch.ready & head_valid),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  // Drive the token channel from the queue head
  assign out_ch.valid       = head_valid;
  assign out_ch.kind        = head.kind;
  assign out_ch.line        = head.line;
  assign out_ch.column      = head.column;
  assign out_ch.sym_offset  = head.sym_offset;
  assign out_ch.sym_length  = head.sym_length;
  assign out_ch.int_value   = head.int_value;
  assign out_ch.frac_value  = head.frac_value;
  assign out_ch.frac_digits = head.frac_digits;
  assign out_ch.last        = head.last;

endmodule

@@ tb/sv/tb_source_tokenizer.sv @@
// Self-checking testbench for the streaming source tokenizer.
module tb_source_tokenizer;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS    = 300;
  // Punctuators in kind order, first character in the top byte
  localparam logic [127:0] PUNCT_SET = ",+-*/=.<>:{}[]()";

  typedef enum logic [4:0] {
    SCAN_IDLE    = 5'b00001,
    SCAN_COMMENT = 5'b00010,
    SCAN_SYM     = 5'b00100,
    SCAN_INT     = 5'b01000,
    SCAN_FRAC    = 5'b10000
  } scan_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } src_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stok_in_if  in_ch ();
  stok_out_if out_ch ();

  // Values driven onto the channels, known from time zero
  logic       in_valid_q  = 1'b0;
  logic       in_mode_q   = 1'b0;
  logic [7:0] in_byte_q   = 8'h00;
  logic       out_ready_q = 1'b0;

  assign in_ch.valid  = in_valid_q;
  assign in_ch.mode   = in_mode_q;
  assign in_ch.byte_in = in_byte_q;
  assign out_ch.ready = out_ready_q;

  source_tokenizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  src_item_t           feed_q[$];
  stok_pkg::result_t   token_q[$];
  stok_pkg::result_t   step_toks[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  bit          in_taken = 1'b0;

  // Scanner state mirrored by the predictor
  scan_t       scan_st  = SCAN_IDLE;
  logic [19:0] cur_line = 20'd1;
  logic [15:0] cur_col  = 16'd1;
  logic [31:0] byte_pos = '0;
  logic [31:0] tok_start = '0;
  logic [47:0] kw_chars = '0;
  logic [63:0] int_acc  = '0;
  logic [59:0] frac_acc = '0;
  logic [4:0]  frac_cnt = '0;

  // Character classes
  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] punct_at(int i);
    return PUNCT_SET[8*(15-i) +: 8];
  endfunction

  function automatic int punct_slot(logic [7:0] c);
    for (int i = 0; i < 16; i++) begin
      if (punct_at(i) == c) return i;
    end
    return -1;
  endfunction

  function automatic bit char_known(logic [7:0] c);
    return is_blank(c) || is_letter(c) || is_num(c) || c == stok_pkg::CH_US ||
           c == stok_pkg::CH_HASH || punct_slot(c) >= 0;
  endfunction

  // Position counters: column and line saturate, offset wraps
  function automatic void take_byte();
    byte_pos = byte_pos + 32'd1;
    if (cur_col != 16'hFFFF) cur_col = cur_col + 16'd1;
  endfunction

  function automatic void next_line();
    if (cur_line != 20'hFFFFF) cur_line = cur_line + 20'd1;
    cur_col = 16'd1;
  endfunction

  function automatic void emit(stok_pkg::kind_t k, logic [31:0] off, logic [31:0] len,
                               logic [63:0] iv, logic [59:0] fv, logic [4:0] fd);
    stok_pkg::result_t r;
    r.kind        = k;
    r.line        = cur_line;
    r.column      = cur_col;
    r.sym_offset  = off;
    r.sym_length  = len;
    r.int_value   = iv;
    r.frac_value  = fv;
    r.frac_digits = fd;
    r.last        = 1'b0;
    step_toks.push_back(r);
  endfunction

  function automatic stok_pkg::kind_t word_kind();
    if (kw_chars == stok_pkg::KW_PROC) return stok_pkg::KIND_PROC;
    if (kw_chars == stok_pkg::KW_RECORD) return stok_pkg::KIND_RECORD;
    if (kw_chars == stok_pkg::KW_VAR) return stok_pkg::KIND_VAR;
    if (kw_chars == stok_pkg::KW_RETURN) return stok_pkg::KIND_RETURN;
    if (kw_chars == stok_pkg::KW_END) return stok_pkg::KIND_END;
    return stok_pkg::KIND_SYM;
  endfunction

  // Close any token in progress and drop back to idle
  function automatic void flush_pending();
    case (scan_st)
      SCAN_SYM: begin
        emit(word_kind(), tok_start, byte_pos - tok_start, '0, '0, '0);
      end
      SCAN_INT: begin
        emit(stok_pkg::KIND_INT, '0, '0, int_acc, '0, '0);
      end
      SCAN_FRAC: begin
        emit(stok_pkg::KIND_REAL, '0, '0, int_acc, frac_acc, frac_cnt);
      end
      default: begin
      end
    endcase
    scan_st = SCAN_IDLE;
  endfunction

  // Byte seen between tokens
  function automatic void scan_idle(logic [7:0] c);
    int slot;
    if (is_blank(c)) begin
      take_byte();
      if (c == stok_pkg::CH_LF) next_line();
    end else if (c == stok_pkg::CH_HASH) begin
      take_byte();
      scan_st = SCAN_COMMENT;
    end else if (is_letter(c) || c == stok_pkg::CH_US) begin
      tok_start = byte_pos;
      kw_chars  = {40'd0, c};
      scan_st   = SCAN_SYM;
      take_byte();
    end else if (is_num(c)) begin
      int_acc  = 64'(c - 8'h30);
      frac_acc = '0;
      frac_cnt = '0;
      scan_st  = SCAN_INT;
      take_byte();
    end else begin
      take_byte();
      slot = punct_slot(c);
      if (slot >= 0) begin
        emit(stok_pkg::kind_t'(stok_pkg::KIND_COMMA + slot), '0, '0, '0, '0, '0);
      end else begin
        emit(stok_pkg::KIND_ERR, '0, '0, '0, '0, '0);
      end
    end
  endfunction

  // Work out the tokens caused by one accepted item and queue them
  function automatic void predict_tokens(logic mode, logic [7:0] c);
    stok_pkg::result_t t;
    step_toks.delete();
    if (mode) begin
      flush_pending();
      emit(stok_pkg::KIND_EOF, '0, '0, '0, '0, '0);
    end else begin
      case (scan_st)
        SCAN_COMMENT: begin
          take_byte();
          if (c == stok_pkg::CH_LF) begin
            next_line();
            scan_st = SCAN_IDLE;
          end
        end
        SCAN_SYM: begin
          if (is_letter(c) || is_num(c) || c == stok_pkg::CH_US) begin
            if (kw_chars[47:40] != 8'd0) kw_chars = stok_pkg::KW_FULL;
            else kw_chars = {kw_chars[39:0], c};
            take_byte();
          end else begin
            flush_pending();
            scan_idle(c);
          end
        end
        SCAN_INT: begin
          if (is_num(c)) begin
            int_acc = int_acc * 64'd10 + 64'(c - 8'h30);
            take_byte();
          end else if (c == stok_pkg::CH_DOT) begin
            take_byte();
            scan_st = SCAN_FRAC;
          end else begin
            flush_pending();
            scan_idle(c);
          end
        end
        SCAN_FRAC: begin
          if (is_num(c)) begin
            // Drop digits past the kept precision
            if (frac_cnt < stok_pkg::MAX_FRAC_DIGITS) begin
              frac_acc = frac_acc * 60'd10 + 60'(c - 8'h30);
              frac_cnt = frac_cnt + 5'd1;
            end
            take_byte();
          end else begin
            flush_pending();
            scan_idle(c);
          end
        end
        default: begin
          scan_idle(c);
        end
      endcase
    end
    if (step_toks.size() != 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  // Source text builders
  function automatic void put_byte(logic [7:0] b);
    feed_q.push_back('{mode: 1'b0, data: b});
  endfunction

  function automatic void put_eof();
    feed_q.push_back('{mode: 1'b1, data: 8'($urandom_range(0, 255))});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_digits(int unsigned n);
    repeat (n) put_byte(8'h30 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] ident_char(bit lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return stok_pkg::CH_US;
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'h20 : 8'(8'h08 + r);
  endfunction

  // One random lexeme, mostly well formed, sometimes noise
  function automatic void add_random_token();
    int unsigned pick, cnt;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      case ($urandom_range(0, 4))
        0: put_text("proc");
        1: put_text("record");
        2: put_text("var");
        3: put_text("return");
        default: put_text("end");
      endcase
      if ($urandom_range(0, 3) == 0) put_byte(ident_char(1'b0));
    end else if (pick < 30) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      put_byte(ident_char(1'b1));
      repeat (cnt - 1) put_byte(ident_char(1'b0));
    end else if (pick < 45) begin
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 6);
      put_digits(cnt);
    end else if (pick < 57) begin
      put_digits($urandom_range(1, 4));
      put_byte(stok_pkg::CH_DOT);
      case ($urandom_range(0, 6))
        0: cnt = 0;
        1: cnt = $urandom_range(17, 24);
        default: cnt = $urandom_range(1, 6);
      endcase
      put_digits(cnt);
    end else if (pick < 75) begin
      put_byte(punct_at($urandom_range(0, 15)));
    end else if (pick < 80) begin
      put_byte(stok_pkg::CH_HASH);
      repeat ($urandom_range(0, 10)) begin
        do b = 8'($urandom_range(0, 255)); while (b == stok_pkg::CH_LF);
        put_byte(b);
      end
      if ($urandom_range(0, 4) != 0) put_byte(stok_pkg::CH_LF);
    end else if (pick < 84) begin
      do b = 8'($urandom_range(0, 255)); while (char_known(b));
      put_byte(b);
    end else if (pick < 88) begin
      put_eof();
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 3)) put_byte(blank_char());
    end else begin
      put_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0) put_byte(blank_char());
  endfunction

  // Driver: hold an item until its transfer, then advance or idle
  always @(negedge clk) begin
    src_item_t nxt;
    if (rst_n) begin
      if (!in_valid_q || in_taken) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = feed_q.pop_front();
          in_valid_q <= 1'b1;
          in_mode_q  <= nxt.mode;
          in_byte_q  <= nxt.data;
        end else begin
          in_valid_q <= 1'b0;
        end
      end
      out_ready_q <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void show_token(string tag, stok_pkg::result_t r);
    $display("  %s kind %0d line %0d col %0d off %0d len %0d int %0d frac %0d/%0d last %0d",
             tag, r.kind, r.line, r.column, r.sym_offset, r.sym_length, r.int_value,
             r.frac_value, r.frac_digits, r.last);
  endfunction

  // Monitor: check each token transfer, predict from each byte transfer
  always @(posedge clk) begin
    stok_pkg::result_t got, want;
    bit out_taken;
    in_taken  = (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
    out_taken = (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
    if (rst_n) begin
      if (out_taken) begin
        got.kind        = out_ch.kind;
        got.line        = out_ch.line;
        got.column      = out_ch.column;
        got.sym_offset  = out_ch.sym_offset;
        got.sym_length  = out_ch.sym_length;
        got.int_value   = out_ch.int_value;
        got.frac_value  = out_ch.frac_value;
        got.frac_digits = out_ch.frac_digits;
        got.last        = out_ch.last;
        if (token_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected token");
            show_token("got ", got);
          end
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("token mismatch");
              show_token("want", want);
              show_token("got ", got);
            end
          end
        end
      end
      if (in_taken) predict_tokens(in_ch.mode, in_ch.byte_in);
      // Watchdog on cycles without any transfer
      if (in_taken || out_taken) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_source_tokenizer NOT OK");
        $finish;
      end
    end
  end

  // Stimulus: directed opening, then random phases
  initial begin
    int unsigned base;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct = 20; recv_stall_pct = 20;
        end
      endcase
      if (ph == 0) begin
        // Keyword, symbol, real without fraction, punctuators, comment with a high byte,
        // unknown byte, token flushed by end of source, repeated end of source
        put_text("var{_Z9 1.}<4.25#");
        put_byte(8'hFF);
        put_byte(stok_pkg::CH_LF);
        put_byte(8'h80);
        put_text("q");
        put_eof();
        put_eof();
        put_text("ab,");
        put_byte(stok_pkg::CH_LF);
      end
      base = feed_q.size();
      while (feed_q.size() - base < PHASE_ITEMS) add_random_token();
      @(negedge clk);
      while (feed_q.size() != 0 || in_valid_q) @(negedge clk);
    end
    while (token_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) $display("tb_source_tokenizer OK");
    else $display("tb_source_tokenizer NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/stok_pkg.sv
hw/rtl/stok_if.sv
hw/rtl/stok_scan.sv
hw/rtl/stok_fifo.sv
hw/rtl/source_tokenizer.sv
tb/sv/tb_source_tokenizer.sv
